>>> rtl/core/tmtf_pkg.sv
`timescale 1ns / 1ps
package tmtf_pkg;

   // field widths of the channels and the register port
   localparam int OPCODE_W   = 2;
   localparam int GRID_W     = 7;
   localparam int VALUE_W    = 11;
   localparam int SLOT_IN_W  = 4;
   localparam int SCREEN_W   = 14;
   localparam int FRAME_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SIZE_W     = 7;
   localparam int FINE_W     = 6;
   localparam int ALPHA_W    = 8;

   // shared serial divider
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = 4;

   localparam logic [SIZE_W-1:0]  TILE_MAX     = 7'd64;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [OPCODE_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_ANIM  = 2'd2,
      OP_FETCH = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_SCROLL_X    = 3'd0,
      CFG_SCROLL_Y    = 3'd1,
      CFG_TILE_WIDTH  = 3'd2,
      CFG_TILE_HEIGHT = 3'd3,
      CFG_MAP_WIDTH   = 3'd4,
      CFG_MAP_HEIGHT  = 3'd5,
      CFG_EMPTY_ZERO  = 3'd6,
      CFG_ALPHA       = 3'd7
   } cfg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_ISSUE,
      ST_DIV_WAIT,
      ST_ADDR,
      ST_ACCESS,
      ST_RWAIT,
      ST_FINISH,
      ST_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      DS_WRAP_X,
      DS_TILE_X,
      DS_CELL_X,
      DS_WRAP_Y,
      DS_TILE_Y,
      DS_CELL_Y
   } div_step_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

>>> rtl/core/tmtf_channels.sv
`timescale 1ns / 1ps
interface tmtf_req_if;
   import tmtf_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [OPCODE_W-1:0]         opcode;
   logic [GRID_W-1:0]           col;
   logic [GRID_W-1:0]           row;
   logic signed [VALUE_W-1:0]   value;
   logic [SLOT_IN_W-1:0]        anim_slot;

   modport source (output valid, opcode, col, row, value, anim_slot, input ready);
   modport sink   (input valid, opcode, col, row, value, anim_slot, output ready);
endinterface

interface tmtf_rsp_if;
   import tmtf_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [SCREEN_W-1:0]  screen_x;
   logic signed [SCREEN_W-1:0]  screen_y;
   logic [FRAME_W-1:0]          tile_frame;
   logic                        draw;
   logic                        blend;
   logic signed [VALUE_W-1:0]   read_data;

   modport source (output valid, screen_x, screen_y, tile_frame, draw, blend, read_data,
                   input ready);
   modport sink   (input valid, screen_x, screen_y, tile_frame, draw, blend, read_data,
                   output ready);
endinterface

>>> rtl/core/tmtf_div.sv
`timescale 1ns / 1ps
module tmtf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tmtf_pkg::div_req_type req,
   output tmtf_pkg::div_rsp_type rsp
);
   import tmtf_pkg::*;

   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     dvsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       diff;
   logic                 ge;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dvsr_ff};
      ge      = (shifted >= {1'b0, dvsr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= '0;
         quo_ff  <= req.dividend;
         dvsr_ff <= req.divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

>>> rtl/core/tmtf_map_mem.sv
`timescale 1ns / 1ps
module tmtf_map_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [tmtf_pkg::VALUE_W-1:0]  wr_data,
   input  logic                                 rd_en,
   input  logic [AW-1:0]                        rd_addr,
   output logic signed [tmtf_pkg::VALUE_W-1:0]  rd_data
);
   import tmtf_pkg::*;

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tmtf_anim_table.sv
`timescale 1ns / 1ps
module tmtf_anim_table #(
   parameter int SLOTS = 16,
   parameter int SW    = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [SW-1:0]                 wr_addr,
   input  logic [tmtf_pkg::FRAME_W-1:0]  wr_data,
   input  logic [SW-1:0]                 rd_addr,
   output logic [tmtf_pkg::FRAME_W-1:0]  rd_data
);
   import tmtf_pkg::*;

   logic [FRAME_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [FRAME_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   // a slot never written reads as frame zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> rtl/core/tilemap_plane_tile_fetch_unit.sv
`timescale 1ns / 1ps
// Tile fetch for a wrapping tilemap background layer.
// Transactions arrive on req_ch (valid/ready) and each one gives exactly one
// transaction on rsp_ch. Opcodes: write a map cell, read a map cell, set the
// current frame of an animation slot, or fetch the tile at a visible grid
// position. The user must write registers on the csr_ port (write enable,
// index, data) only while the block is idle; the block does not enforce it.
// A fetch runs six divisions (two scroll wraps, two tile splits, two map
// wraps) one after another through a single 16-step restoring divider;
// that divider sets the fetch rate. A cell write passes ST_ADDR, ST_ACCESS
// and ST_FINISH to ST_OUT, a cell read adds ST_RWAIT after ST_ACCESS, and
// an animation set goes from ST_IDLE straight to ST_ACCESS. One transaction
// is in flight at a time: a new one is taken only in idle, after the
// response handshake.
// After reset the map memory is swept to zero, one entry per cycle, over all
// MAP_MAX_COLS*MAP_MAX_ROWS entries (4096 by default); req_ch.ready stays low
// until then, register writes are taken as usual. A stalled receiver holds
// the response registered and keeps req_ch.ready low until it is taken.
module tilemap_plane_tile_fetch_unit #(
   parameter int MAP_MAX_COLS = 64,
   parameter int MAP_MAX_ROWS = 64,
   parameter int ANIM_SLOTS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   tmtf_req_if.sink                           req_ch,
   tmtf_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [tmtf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tmtf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tmtf_pkg::*;

   localparam int MAP_DEPTH = MAP_MAX_COLS * MAP_MAX_ROWS;
   localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int MW_W      = $clog2(MAP_MAX_COLS + 1);
   localparam int MH_W      = $clog2(MAP_MAX_ROWS + 1);
   localparam int SLOT_W    = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;

   // configuration registers
   logic signed [CSR_DATA_W-1:0] scroll_x_ff;
   logic signed [CSR_DATA_W-1:0] scroll_y_ff;
   logic [SIZE_W-1:0]            tile_width_ff;
   logic [SIZE_W-1:0]            tile_height_ff;
   logic [SIZE_W-1:0]            map_width_ff;
   logic [SIZE_W-1:0]            map_height_ff;
   logic                         empty_zero_ff;
   logic [ALPHA_W-1:0]           alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff    <= '0;
         scroll_y_ff    <= '0;
         tile_width_ff  <= 7'd8;
         tile_height_ff <= 7'd8;
         map_width_ff   <= 7'd64;
         map_height_ff  <= 7'd64;
         empty_zero_ff  <= 1'b1;
         alpha_ff       <= ALPHA_OPAQUE;
      end else if (csr_we) begin
         case (cfg_index_type'(csr_index))
            CFG_SCROLL_X:    scroll_x_ff    <= csr_wdata;
            CFG_SCROLL_Y:    scroll_y_ff    <= csr_wdata;
            CFG_TILE_WIDTH:  tile_width_ff  <= csr_wdata[SIZE_W-1:0];
            CFG_TILE_HEIGHT: tile_height_ff <= csr_wdata[SIZE_W-1:0];
            CFG_MAP_WIDTH:   map_width_ff   <= csr_wdata[SIZE_W-1:0];
            CFG_MAP_HEIGHT:  map_height_ff  <= csr_wdata[SIZE_W-1:0];
            CFG_EMPTY_ZERO:  empty_zero_ff  <= csr_wdata[0];
            CFG_ALPHA:       alpha_ff       <= csr_wdata[ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped sizes
   logic [SIZE_W-1:0] tw_c, th_c;
   logic [MW_W-1:0]   mw_c;
   logic [MH_W-1:0]   mh_c;

   always_comb begin
      if (tile_width_ff == '0)         tw_c = SIZE_W'(1);
      else if (tile_width_ff > TILE_MAX) tw_c = TILE_MAX;
      else                              tw_c = tile_width_ff;
      if (tile_height_ff == '0)         th_c = SIZE_W'(1);
      else if (tile_height_ff > TILE_MAX) th_c = TILE_MAX;
      else                              th_c = tile_height_ff;
      if (map_width_ff == '0)                        mw_c = MW_W'(1);
      else if (int'(map_width_ff) > MAP_MAX_COLS)    mw_c = MW_W'(MAP_MAX_COLS);
      else                                           mw_c = MW_W'(map_width_ff);
      if (map_height_ff == '0)                       mh_c = MH_W'(1);
      else if (int'(map_height_ff) > MAP_MAX_ROWS)   mh_c = MH_W'(MAP_MAX_ROWS);
      else                                           mh_c = MH_W'(map_height_ff);
   end

   // transaction registers
   opcode_type                op_ff;
   logic [GRID_W-1:0]         col_ff, row_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [SLOT_IN_W-1:0]      slot_ff;
   logic [SIZE_W-1:0]         tw_ff, th_ff;
   logic [MW_W-1:0]           mw_ff;
   logic [MH_W-1:0]           mh_ff;
   logic [DIV_W-1:0]          ext_x_ff, ext_y_ff;

   logic [DIV_W-1:0]          wx_ff, wy_ff;
   logic [MW_W-1:0]           qx_ff, cx_ff;
   logic [MH_W-1:0]           qy_ff, cy_ff;
   logic [FINE_W-1:0]         fx_ff, fy_ff;
   logic [MAP_AW-1:0]         addr_ff;
   logic                      in_range_ff;
   logic signed [VALUE_W-1:0] entry_ff;
   logic                      slot_hit_ff;
   logic [MAP_AW-1:0]         clear_addr_ff;

   logic [SCREEN_W-1:0]       px_ff, py_ff;
   logic [SCREEN_W-1:0]       out_x_ff, out_y_ff;
   logic [FRAME_W-1:0]        out_frame_ff;
   logic                      out_draw_ff, out_blend_ff;
   logic signed [VALUE_W-1:0] out_rd_ff;

   seq_state_type state_ff, state_in;
   div_step_type  step_ff, step_in;

   div_req_type               div_req;
   div_rsp_type               div_rsp;

   logic                      map_we, map_re;
   logic [MAP_AW-1:0]         map_waddr;
   logic signed [VALUE_W-1:0] map_wdata;
   logic signed [VALUE_W-1:0] map_rdata;

   logic                      anim_we;
   logic [FRAME_W-1:0]        anim_wdata;
   logic [FRAME_W-1:0]        anim_rdata;
   logic [FRAME_W-1:0]        anim_k;

   logic                      req_fire;
   logic [DIV_W-1:0]          div_fix;

   assign req_fire = req_ch.valid && req_ch.ready;

   // negative entry -k names slot k-1, which is the bitwise inverse
   assign anim_k     = ~map_rdata[FRAME_W-1:0];
   assign anim_wdata = val_ff[VALUE_W-1] ? '0 : val_ff[FRAME_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= DS_WRAP_X;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      req_ch.ready     = 1'b0;
      rsp_ch.valid     = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = DIV_W'(1);
      map_we           = 1'b0;
      map_re           = 1'b0;
      map_waddr        = addr_ff;
      map_wdata        = val_ff;
      anim_we          = 1'b0;

      case (step_ff)
         DS_WRAP_X: begin
            div_req.dividend = scroll_x_ff[CSR_DATA_W-1] ? DIV_W'(-scroll_x_ff)
                                                         : DIV_W'(scroll_x_ff);
            div_req.divisor  = ext_x_ff;
         end
         DS_TILE_X: begin
            div_req.dividend = wx_ff;
            div_req.divisor  = DIV_W'(tw_ff);
         end
         DS_CELL_X: begin
            div_req.dividend = DIV_W'(qx_ff) + DIV_W'(col_ff);
            div_req.divisor  = DIV_W'(mw_ff);
         end
         DS_WRAP_Y: begin
            div_req.dividend = scroll_y_ff[CSR_DATA_W-1] ? DIV_W'(-scroll_y_ff)
                                                         : DIV_W'(scroll_y_ff);
            div_req.divisor  = ext_y_ff;
         end
         DS_TILE_Y: begin
            div_req.dividend = wy_ff;
            div_req.divisor  = DIV_W'(th_ff);
         end
         DS_CELL_Y: begin
            div_req.dividend = DIV_W'(qy_ff) + DIV_W'(row_ff);
            div_req.divisor  = DIV_W'(mh_ff);
         end
         default: ;
      endcase

      case (state_ff)
         ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clear_addr_ff;
            map_wdata = '0;
            if (clear_addr_ff == MAP_AW'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               step_in = DS_WRAP_X;
               case (opcode_type'(req_ch.opcode))
                  OP_FETCH: state_in = ST_DIV_ISSUE;
                  OP_ANIM:  state_in = ST_ACCESS;
                  default:  state_in = ST_ADDR;
               endcase
            end
         end
         ST_DIV_ISSUE: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (step_ff)
                  DS_WRAP_X: begin step_in = DS_TILE_X; state_in = ST_DIV_ISSUE; end
                  DS_TILE_X: begin step_in = DS_CELL_X; state_in = ST_DIV_ISSUE; end
                  DS_CELL_X: begin step_in = DS_WRAP_Y; state_in = ST_DIV_ISSUE; end
                  DS_WRAP_Y: begin step_in = DS_TILE_Y; state_in = ST_DIV_ISSUE; end
                  DS_TILE_Y: begin step_in = DS_CELL_Y; state_in = ST_DIV_ISSUE; end
                  default:   state_in = ST_ADDR;
               endcase
            end
         end
         ST_ADDR: begin
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            case (op_ff)
               OP_WRITE: begin
                  map_we   = in_range_ff;
                  state_in = ST_FINISH;
               end
               OP_ANIM: begin
                  anim_we  = (int'(slot_ff) < ANIM_SLOTS);
                  state_in = ST_FINISH;
               end
               default: begin
                  map_re   = 1'b1;
                  state_in = ST_RWAIT;
               end
            endcase
         end
         ST_RWAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // wrap toward zero and fold a negative remainder back into the extent
   always_comb begin
      div_fix = div_rsp.rem;
      if (step_ff == DS_WRAP_X && scroll_x_ff[CSR_DATA_W-1] && div_rsp.rem != '0) begin
         div_fix = ext_x_ff - div_rsp.rem;
      end else if (step_ff == DS_WRAP_Y && scroll_y_ff[CSR_DATA_W-1] &&
                   div_rsp.rem != '0) begin
         div_fix = ext_y_ff - div_rsp.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= opcode_type'(req_ch.opcode);
         col_ff   <= req_ch.col;
         row_ff   <= req_ch.row;
         val_ff   <= req_ch.value;
         slot_ff  <= req_ch.anim_slot;
         tw_ff    <= tw_c;
         th_ff    <= th_c;
         mw_ff    <= mw_c;
         mh_ff    <= mh_c;
         ext_x_ff <= DIV_W'(DIV_W'(mw_c) * DIV_W'(tw_c));
         ext_y_ff <= DIV_W'(DIV_W'(mh_c) * DIV_W'(th_c));
      end

      if (state_ff == ST_DIV_WAIT && div_rsp.done) begin
         case (step_ff)
            DS_WRAP_X: wx_ff <= div_fix;
            DS_TILE_X: begin
               qx_ff <= MW_W'(div_rsp.quot);
               fx_ff <= div_rsp.rem[FINE_W-1:0];
            end
            DS_CELL_X: cx_ff <= MW_W'(div_rsp.rem);
            DS_WRAP_Y: wy_ff <= div_fix;
            DS_TILE_Y: begin
               qy_ff <= MH_W'(div_rsp.quot);
               fy_ff <= div_rsp.rem[FINE_W-1:0];
            end
            DS_CELL_Y: cy_ff <= MH_W'(div_rsp.rem);
            default: ;
         endcase
      end

      if (state_ff == ST_ADDR) begin
         if (op_ff == OP_FETCH) begin
            addr_ff     <= MAP_AW'(DIV_W'(cy_ff) * DIV_W'(mw_ff) + DIV_W'(cx_ff));
            in_range_ff <= 1'b1;
         end else begin
            addr_ff     <= MAP_AW'(DIV_W'(row_ff) * DIV_W'(mw_ff) + DIV_W'(col_ff));
            in_range_ff <= (int'(col_ff) < int'(mw_ff)) && (int'(row_ff) < int'(mh_ff));
         end
         px_ff <= SCREEN_W'(SCREEN_W'(col_ff) * SCREEN_W'(tw_ff)) - SCREEN_W'(fx_ff);
         py_ff <= SCREEN_W'(SCREEN_W'(row_ff) * SCREEN_W'(th_ff)) - SCREEN_W'(fy_ff);
      end

      if (state_ff == ST_RWAIT) begin
         entry_ff    <= map_rdata;
         slot_hit_ff <= (int'(anim_k) < ANIM_SLOTS);
      end

      if (state_ff == ST_FINISH) begin
         out_x_ff     <= '0;
         out_y_ff     <= '0;
         out_frame_ff <= '0;
         out_draw_ff  <= 1'b0;
         out_blend_ff <= 1'b0;
         out_rd_ff    <= '0;
         case (op_ff)
            OP_READ: begin
               if (in_range_ff) begin
                  out_rd_ff <= entry_ff;
               end
            end
            OP_FETCH: begin
               out_x_ff     <= px_ff;
               out_y_ff     <= py_ff;
               out_blend_ff <= (alpha_ff != ALPHA_OPAQUE);
               if (entry_ff != '0 || !empty_zero_ff) begin
                  if (entry_ff[VALUE_W-1]) begin
                     if (slot_hit_ff) begin
                        out_frame_ff <= anim_rdata;
                        out_draw_ff  <= 1'b1;
                     end
                  end else begin
                     out_frame_ff <= entry_ff[FRAME_W-1:0];
                     out_draw_ff  <= 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_ch.screen_x   = out_x_ff;
   assign rsp_ch.screen_y   = out_y_ff;
   assign rsp_ch.tile_frame = out_frame_ff;
   assign rsp_ch.draw       = out_draw_ff;
   assign rsp_ch.blend      = out_blend_ff;
   assign rsp_ch.read_data  = out_rd_ff;

   tmtf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tmtf_map_mem #(
      .DEPTH (MAP_DEPTH),
      .AW    (MAP_AW)
   ) u_map_mem (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (addr_ff),
      .rd_data (map_rdata)
   );

   tmtf_anim_table #(
      .SLOTS (ANIM_SLOTS),
      .SW    (SLOT_W)
   ) u_anim_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (anim_we),
      .wr_addr (SLOT_W'(slot_ff)),
      .wr_data (anim_wdata),
      .rd_addr (SLOT_W'(anim_k)),
      .rd_data (anim_rdata)
   );

endmodule
